// ===== src/perceptron_branch_predictor_unit_macros.svh =====
// assertion helpers for the predictor, clocked on clk and quiet during rst
`ifndef PERCEPTRON_BRANCH_PREDICTOR_UNIT_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_UNIT_MACROS_SVH

// same-cycle implication
`define PBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pbp_pkg.sv =====
package pbp_pkg;

  localparam int HISTORY_LEN_DEF = 28;
  localparam int TABLE_ROWS_DEF  = 128;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam int ADDR_W       = 32;
  localparam int THRESH_W     = 8;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd68;
  localparam int SUM_OUT_W    = 13;

  localparam int IN_DATA_W    = ((ADDR_W + 1) + 7) / 8 * 8;
  localparam int OUT_DATA_W   = ((1 + SUM_OUT_W) + 7) / 8 * 8;

  // lanes summed per first-level adder group
  localparam int GROUP_LANES  = 8;

  // cycles of the row modulo unit: reciprocal multiply, then subtract
  localparam int MOD_CYCLES   = 2;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

endpackage

// ===== src/perceptron_branch_predictor_unit.sv =====
// predict: the result is registered in the sum state, after the read state (power-of-two
//   table sizes; other sizes first pass the modulo state for the address modulo unit)
// update: no result; the weight memory reads one row per cycle, and input is taken only
//   in idle, so a new item waits until the last is done and a predict waits on output stalls
// rst (synchronous): history, remembered row/sum/prediction and row valid bits
//   clear, so every weight reads as zero at once; threshold returns to 68
`include "perceptron_branch_predictor_unit_macros.svh"

module perceptron_branch_predictor_unit
  import pbp_pkg::*;
#(
  parameter int HISTORY_LEN = HISTORY_LEN_DEF,
  parameter int TABLE_ROWS  = TABLE_ROWS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // branch_addr[31:0], taken[32], zero pad
  input  logic                  s_axis_tuser,   // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // predict_taken[0], perceptron_sum[13:1], pad
  input  logic                  cfg_we,
  input  logic [THRESH_W-1:0]   cfg_wdata
);

  localparam int LANES    = HISTORY_LEN + 1;
  localparam int ROW_W    = LANES * WEIGHT_BITS;
  localparam int ROW_AW   = $clog2(TABLE_ROWS);
  localparam int SUM_W    = WEIGHT_BITS + $clog2(LANES);
  localparam int NG       = (LANES + GROUP_LANES - 1) / GROUP_LANES;
  localparam int PART_W   = WEIGHT_BITS + 1 + $clog2(GROUP_LANES);
  localparam int ACC_W    = SUM_W + PART_W;
  localparam int EXT_W    = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int CMP_W    = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
  localparam int MOD_CW   = $clog2(MOD_CYCLES);
  localparam bit ROWS_POW2 = (TABLE_ROWS & (TABLE_ROWS - 1)) == 0;
  localparam int PAD_W    = OUT_DATA_W - 1 - SUM_OUT_W;
  localparam int RECIP_SH = ADDR_W + ROW_AW;
  localparam int PROD_W   = 2 * ADDR_W + 1;
  localparam logic [ADDR_W:0] RECIP =
    (ADDR_W+1)'(((longint'(1) << RECIP_SH) + TABLE_ROWS - 1) / TABLE_ROWS);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_READ, S_SUM} state_t;

  state_t                   state;
  logic [THRESH_W-1:0]      train_threshold;
  logic [HISTORY_LEN-1:0]   global_history;
  logic [ROW_AW-1:0]        last_row;
  logic signed [SUM_W-1:0]  last_sum;
  logic                     last_prediction;
  logic [TABLE_ROWS-1:0]    row_valid;

  logic                     op_is_update;
  logic                     upd_taken;
  logic [ROW_AW-1:0]        op_row;
  logic [ROW_AW-1:0]        op_row_next;
  logic [ADDR_W-1:0]        addr_sh;
  logic [PROD_W-1:0]        mod_prod;
  logic [ROW_AW-1:0]        mod_quo;
  logic [ROW_AW-1:0]        mod_sub;
  logic [ROW_AW-1:0]        mod_rem_next;
  logic [MOD_CW-1:0]        mod_cnt;

  logic [ROW_W-1:0]         row_mem [TABLE_ROWS];
  logic [ROW_W-1:0]         rdata;
  logic                     rvalid;
  logic [ROW_W-1:0]         row_data;
  logic [ROW_W-1:0]         trained_row;
  logic                     train_en;
  logic                     upd_stage;
  logic                     mem_we;

  logic signed [WEIGHT_BITS:0]  terms [LANES];
  logic signed [PART_W-1:0]     part_next [NG];
  logic signed [PART_W-1:0]     part [NG];
  logic signed [ACC_W-1:0]      total_acc;
  logic signed [SUM_W-1:0]      total;
  logic signed [EXT_W-1:0]      total_ext;
  logic [SUM_W-1:0]             last_mag;

  logic in_fire;

  function automatic logic [WEIGHT_BITS-1:0] sat_step(logic [WEIGHT_BITS-1:0] w, logic up);
    logic [WEIGHT_BITS-1:0] wmax;
    logic [WEIGHT_BITS-1:0] wmin;
    wmax = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    wmin = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    if (up) begin
      sat_step = (w == wmax) ? w : w + WEIGHT_BITS'(1);
    end else begin
      sat_step = (w == wmin) ? w : w - WEIGHT_BITS'(1);
    end
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // address modulo by reciprocal multiply: low quotient bits first, then the
  // remainder from the low bits of address and quotient times rows
  assign mod_prod     = PROD_W'(addr_sh) * PROD_W'(RECIP);
  assign mod_sub      = mod_quo * ROW_AW'(TABLE_ROWS);
  assign mod_rem_next = addr_sh[ROW_AW-1:0] - mod_sub;

  always_comb begin
    op_row_next = op_row;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == CMD_UPDATE) begin
            op_row_next = last_row;
          end else if (ROWS_POW2) begin
            op_row_next = s_axis_tdata[ROW_AW-1:0];
          end
        end
      end
      S_MOD: begin
        if (mod_cnt == MOD_CW'(MOD_CYCLES - 1)) begin
          op_row_next = mod_rem_next;
        end
      end
      default: ;
    endcase
  end

  // rows never written since reset read as zero
  assign row_data = rvalid ? rdata : '0;

  always_comb begin
    terms[0] = (WEIGHT_BITS+1)'($signed(row_data[WEIGHT_BITS-1:0]));
    for (int l = 1; l < LANES; l++) begin
      if (global_history[l-1]) begin
        terms[l] = (WEIGHT_BITS+1)'($signed(row_data[l*WEIGHT_BITS +: WEIGHT_BITS]));
      end else begin
        terms[l] = -(WEIGHT_BITS+1)'($signed(row_data[l*WEIGHT_BITS +: WEIGHT_BITS]));
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < GROUP_LANES; k++) begin
        if (g * GROUP_LANES + k < LANES) begin
          part_next[g] = part_next[g] + PART_W'(terms[g * GROUP_LANES + k]);
        end
      end
    end
  end

  always_comb begin
    total_acc = '0;
    for (int g = 0; g < NG; g++) begin
      total_acc = total_acc + ACC_W'(part[g]);
    end
    total     = total_acc[SUM_W-1:0];
    total_ext = EXT_W'(total);
  end

  always_comb begin
    trained_row[WEIGHT_BITS-1:0] = sat_step(row_data[WEIGHT_BITS-1:0], upd_taken);
    for (int l = 1; l < LANES; l++) begin
      trained_row[l*WEIGHT_BITS +: WEIGHT_BITS] =
        sat_step(row_data[l*WEIGHT_BITS +: WEIGHT_BITS], global_history[l-1] == upd_taken);
    end
  end

  assign last_mag  = last_sum[SUM_W-1] ? SUM_W'(-last_sum) : SUM_W'(last_sum);
  assign train_en  = (upd_taken != last_prediction) ||
                     (CMP_W'(last_mag) <= CMP_W'(train_threshold));
  assign upd_stage = (state == S_READ) && op_is_update;
  assign mem_we    = upd_stage && train_en;

  always_ff @(posedge clk) begin
    rdata <= row_mem[op_row_next];
    if (mem_we) begin
      row_mem[op_row] <= trained_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
      train_threshold <= THRESH_RESET;
      global_history  <= '0;
      last_row        <= '0;
      last_sum        <= '0;
      last_prediction <= 1'b0;
      row_valid       <= '0;
      rvalid          <= 1'b0;
      op_row          <= '0;
      op_is_update    <= 1'b0;
      mod_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        train_threshold <= cfg_wdata;
      end
      op_row <= op_row_next;
      rvalid <= row_valid[op_row_next];
      // the sum stage always leaves valid high, so only clear elsewhere
      if (m_axis_tvalid && m_axis_tready && state != S_SUM) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_is_update <= (s_axis_tuser == CMD_UPDATE);
            upd_taken    <= s_axis_tdata[ADDR_W];
            addr_sh      <= s_axis_tdata[ADDR_W-1:0];
            mod_cnt      <= '0;
            if (s_axis_tuser == CMD_UPDATE || ROWS_POW2) begin
              state <= S_READ;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          mod_quo <= mod_prod[RECIP_SH +: ROW_AW];
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == MOD_CW'(MOD_CYCLES - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (op_is_update) begin
            if (train_en) begin
              row_valid[op_row] <= 1'b1;
            end
            global_history <= (global_history << 1) | HISTORY_LEN'(upd_taken);
            state <= S_IDLE;
          end else begin
            part  <= part_next;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // wait here while the previous result is still held
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata    <= {{PAD_W{1'b0}}, total_ext[SUM_OUT_W-1:0], ~total[SUM_W-1]};
            m_axis_tvalid   <= 1'b1;
            last_row        <= op_row;
            last_sum        <= total;
            last_prediction <= ~total[SUM_W-1];
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PBP_ASSERT_IMP(a_out_from_sum, $rose(m_axis_tvalid), $past(state) == S_SUM, "stray result")
  `PBP_ASSERT_NXT(a_write_marks_row, mem_we, row_valid[$past(op_row)], "row not marked valid")
  `PBP_ASSERT_IMP(a_row_in_range, state == S_READ, op_row < TABLE_ROWS, "row out of range")
  `PBP_ASSERT_NXT(a_update_silent, upd_stage && !m_axis_tvalid, !m_axis_tvalid, "update gave a result")

endmodule
